[rtl/core/image_crop_mirror_normalize_top_defines.svh]
// assertion macros used by the checker file
`ifndef IMAGE_CROP_MIRROR_NORMALIZE_TOP_DEFINES_SVH
`define IMAGE_CROP_MIRROR_NORMALIZE_TOP_DEFINES_SVH

// property checked only outside reset
`define ICMN_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every edge, reset included
`define ICMN_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/icmn_pkg.sv]
// shared constants and types of the crop, mirror and normalize block
package icmn_pkg;

  localparam int CHANNELS = 3;
  localparam int MAX_DIM  = 1024;

  localparam int DIM_W   = $clog2(MAX_DIM) + 1;
  localparam int POS_W   = $clog2(MAX_DIM);
  localparam int CHAN_W  = 2;
  localparam int PIX_W   = 8;
  localparam int VIEW_W  = 3;
  localparam int MEAN_W  = 16;
  localparam int SCALE_W = 20;
  localparam int NORM_W  = 29;
  localparam int FRAC_SH = 8;
  localparam int DIFF_W  = PIX_W + FRAC_SH + 2;
  localparam int PROD_W  = DIFF_W + SCALE_W + 1;

  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 3;
  localparam int APB_ADDR_W = REG_IDX_W + 2;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  localparam logic [VIEW_W-1:0] VIEW_CENTRE       = 3'd0;
  localparam logic [VIEW_W-1:0] VIEW_TOP_LEFT     = 3'd1;
  localparam logic [VIEW_W-1:0] VIEW_TOP_RIGHT    = 3'd2;
  localparam logic [VIEW_W-1:0] VIEW_BOTTOM_LEFT  = 3'd3;
  localparam logic [VIEW_W-1:0] VIEW_BOTTOM_RIGHT = 3'd4;
  localparam logic [VIEW_W-1:0] VIEW_GIVEN        = 3'd5;

  localparam logic [REG_IDX_W-1:0] REG_ORIG_HEIGHT = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ORIG_WIDTH  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CROP_HEIGHT = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CROP_WIDTH  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SCALE       = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_MEAN_RED    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_MEAN_GREEN  = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_MEAN_BLUE   = 3'd7;

  localparam logic [DIM_W-1:0]   RST_ORIG_HEIGHT = DIM_W'(256);
  localparam logic [DIM_W-1:0]   RST_ORIG_WIDTH  = DIM_W'(256);
  localparam logic [DIM_W-1:0]   RST_CROP_HEIGHT = DIM_W'(224);
  localparam logic [DIM_W-1:0]   RST_CROP_WIDTH  = DIM_W'(224);
  localparam logic [SCALE_W-1:0] RST_SCALE       = SCALE_W'(65536);

  typedef struct packed {
    logic signed [DIFF_W-1:0] diff;
    logic [CHAN_W-1:0]        chan;
    logic [POS_W-1:0]         row;
    logic [POS_W-1:0]         col;
    logic                     last;
  } stage_t;

endpackage

[rtl/core/icmn_in_if.sv]
// input channel: image-start items and pixel bytes
interface icmn_in_if;
  logic                                     valid;
  logic                                     ready;
  logic                                     kind;
  logic [icmn_pkg::PIX_W-1:0]               pixel;
  logic [icmn_pkg::VIEW_W-1:0]              view;
  logic [icmn_pkg::POS_W-1:0]               row_offset;
  logic [icmn_pkg::POS_W-1:0]               col_offset;
  logic                                     mirror;

  modport source (output valid, kind, pixel, view, row_offset, col_offset, mirror,
                  input ready);
  modport sink   (input valid, kind, pixel, view, row_offset, col_offset, mirror,
                  output ready);
endinterface

[rtl/core/icmn_out_if.sv]
// output channel: normalized samples with their destination
interface icmn_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [icmn_pkg::NORM_W-1:0]  norm_value;
  logic [icmn_pkg::CHAN_W-1:0]         out_channel;
  logic [icmn_pkg::POS_W-1:0]          out_row;
  logic [icmn_pkg::POS_W-1:0]          out_col;
  logic                                last_of_image;

  modport source (output valid, norm_value, out_channel, out_row, out_col, last_of_image,
                  input ready);
  modport sink   (input valid, norm_value, out_channel, out_row, out_col, last_of_image,
                  output ready);
endinterface

[rtl/core/image_crop_mirror_normalize_top.sv]
// Crop, mirror and mean/scale normalize of a byte stream, one source byte per cycle
// unless the output stalls. An image-start item (kind 0) picks the crop window and the
// mirror flag and rewinds the source position; it gives no result. Each pixel byte
// (kind 1) that falls inside the window gives a result, held in stage 1 and then in the
// output register: (byte - channel mean) * scale rounded and saturated to signed Q12.16,
// with its channel-first destination and a mark on the image's last sample. The
// window test and the mean subtract sit in the first stage, the 18 x 21 bit multiply
// with rounding and saturation in the second, which loads the output register. Both
// stages move while the downstream side takes results, so the sustained rate is one byte per cycle.
// The user must set sizes, scale and means through the APB port while idle; the block does not enforce it.
module image_crop_mirror_normalize_top (
  input  logic                               clk,
  input  logic                               rst,
  icmn_in_if.sink                            din,
  icmn_out_if.source                         dout,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [icmn_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [icmn_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [icmn_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready
);

  // configuration registers
  logic [icmn_pkg::DIM_W-1:0]   orig_height, orig_width, crop_height, crop_width;
  logic [icmn_pkg::SCALE_W-1:0] scale;
  logic [icmn_pkg::MEAN_W-1:0]  mean_red, mean_green, mean_blue;

  logic [icmn_pkg::REG_IDX_W-1:0] reg_idx;
  logic                           cfg_wr;

  // crop state
  logic [icmn_pkg::POS_W-1:0]  cur_row, cur_col, top_row, left_col;
  logic [icmn_pkg::CHAN_W-1:0] cur_chan;
  logic                        flip_on;

  logic [icmn_pkg::POS_W-1:0]  cur_row_next, cur_col_next, top_row_next, left_col_next;
  logic [icmn_pkg::CHAN_W-1:0] cur_chan_next;

  // effective sizes
  logic [icmn_pkg::DIM_W-1:0] oh, ow, ch, cw, ch_m1, cw_m1;
  logic [icmn_pkg::POS_W-1:0] sh, sw, ro_sat, co_sat;

  // window test
  logic [icmn_pkg::POS_W-1:0]  dr, dc, oc;
  logic                        hit, last;
  logic [icmn_pkg::MEAN_W-1:0] mean_sel;
  logic signed [icmn_pkg::DIFF_W-1:0] diff;

  // advance
  logic [icmn_pkg::CHAN_W-1:0] chan_inc;
  logic [icmn_pkg::DIM_W-1:0]  col_inc, row_inc, col_adv, row_adv;

  // pipeline
  icmn_pkg::stage_t s1, s1_next;
  logic             s1_valid;
  logic             out_free, s1_move, acc, acc_pixel;

  logic signed [icmn_pkg::PROD_W-1:0] prod, rnd, quo;
  logic signed [icmn_pkg::NORM_W-1:0] sat;
  logic [icmn_pkg::PROD_W-icmn_pkg::NORM_W:0] quo_top;

  // ---------------- APB ----------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[icmn_pkg::APB_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      orig_height <= icmn_pkg::RST_ORIG_HEIGHT;
      orig_width  <= icmn_pkg::RST_ORIG_WIDTH;
      crop_height <= icmn_pkg::RST_CROP_HEIGHT;
      crop_width  <= icmn_pkg::RST_CROP_WIDTH;
      scale       <= icmn_pkg::RST_SCALE;
      mean_red    <= '0;
      mean_green  <= '0;
      mean_blue   <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        icmn_pkg::REG_ORIG_HEIGHT: orig_height <= pwdata[icmn_pkg::DIM_W-1:0];
        icmn_pkg::REG_ORIG_WIDTH:  orig_width  <= pwdata[icmn_pkg::DIM_W-1:0];
        icmn_pkg::REG_CROP_HEIGHT: crop_height <= pwdata[icmn_pkg::DIM_W-1:0];
        icmn_pkg::REG_CROP_WIDTH:  crop_width  <= pwdata[icmn_pkg::DIM_W-1:0];
        icmn_pkg::REG_SCALE:       scale       <= pwdata[icmn_pkg::SCALE_W-1:0];
        icmn_pkg::REG_MEAN_RED:    mean_red    <= pwdata[icmn_pkg::MEAN_W-1:0];
        icmn_pkg::REG_MEAN_GREEN:  mean_green  <= pwdata[icmn_pkg::MEAN_W-1:0];
        icmn_pkg::REG_MEAN_BLUE:   mean_blue   <= pwdata[icmn_pkg::MEAN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      icmn_pkg::REG_ORIG_HEIGHT: prdata = icmn_pkg::APB_DATA_W'(orig_height);
      icmn_pkg::REG_ORIG_WIDTH:  prdata = icmn_pkg::APB_DATA_W'(orig_width);
      icmn_pkg::REG_CROP_HEIGHT: prdata = icmn_pkg::APB_DATA_W'(crop_height);
      icmn_pkg::REG_CROP_WIDTH:  prdata = icmn_pkg::APB_DATA_W'(crop_width);
      icmn_pkg::REG_SCALE:       prdata = icmn_pkg::APB_DATA_W'(scale);
      icmn_pkg::REG_MEAN_RED:    prdata = icmn_pkg::APB_DATA_W'(mean_red);
      icmn_pkg::REG_MEAN_GREEN:  prdata = icmn_pkg::APB_DATA_W'(mean_green);
      icmn_pkg::REG_MEAN_BLUE:   prdata = icmn_pkg::APB_DATA_W'(mean_blue);
      default:                   prdata = '0;
    endcase
  end

  // ---------------- effective sizes ----------------
  always_comb begin
    if (orig_height == '0)
      oh = icmn_pkg::DIM_W'(1);
    else if (orig_height > icmn_pkg::DIM_W'(icmn_pkg::MAX_DIM))
      oh = icmn_pkg::DIM_W'(icmn_pkg::MAX_DIM);
    else
      oh = orig_height;

    if (orig_width == '0)
      ow = icmn_pkg::DIM_W'(1);
    else if (orig_width > icmn_pkg::DIM_W'(icmn_pkg::MAX_DIM))
      ow = icmn_pkg::DIM_W'(icmn_pkg::MAX_DIM);
    else
      ow = orig_width;

    if (crop_height == '0)
      ch = icmn_pkg::DIM_W'(1);
    else if (crop_height > oh)
      ch = oh;
    else
      ch = crop_height;

    if (crop_width == '0)
      cw = icmn_pkg::DIM_W'(1);
    else if (crop_width > ow)
      cw = ow;
    else
      cw = crop_width;
  end

  assign ch_m1 = ch - icmn_pkg::DIM_W'(1);
  assign cw_m1 = cw - icmn_pkg::DIM_W'(1);
  assign sh    = icmn_pkg::POS_W'(oh - ch);
  assign sw    = icmn_pkg::POS_W'(ow - cw);

  assign ro_sat = (din.row_offset > sh) ? sh : din.row_offset;
  assign co_sat = (din.col_offset > sw) ? sw : din.col_offset;

  always_comb begin
    case (din.view)
      icmn_pkg::VIEW_TOP_LEFT: begin
        top_row_next  = '0;
        left_col_next = '0;
      end
      icmn_pkg::VIEW_TOP_RIGHT: begin
        top_row_next  = '0;
        left_col_next = sw;
      end
      icmn_pkg::VIEW_BOTTOM_LEFT: begin
        top_row_next  = sh;
        left_col_next = '0;
      end
      icmn_pkg::VIEW_BOTTOM_RIGHT: begin
        top_row_next  = sh;
        left_col_next = sw;
      end
      icmn_pkg::VIEW_GIVEN: begin
        top_row_next  = ro_sat;
        left_col_next = co_sat;
      end
      default: begin
        // centre, also for the unused codes
        top_row_next  = sh >> 1;
        left_col_next = sw >> 1;
      end
    endcase
  end

  // ---------------- window test and mean subtract ----------------
  assign dr = cur_row - top_row;
  assign dc = cur_col - left_col;
  assign hit = (cur_row >= top_row) && ({1'b0, dr} < ch) &&
               (cur_col >= left_col) && ({1'b0, dc} < cw) &&
               (cur_chan < icmn_pkg::CHAN_W'(icmn_pkg::CHANNELS));
  assign oc   = flip_on ? icmn_pkg::POS_W'(cw_m1 - {1'b0, dc}) : dc;
  assign last = ({1'b0, dr} == ch_m1) && ({1'b0, dc} == cw_m1) &&
                (cur_chan == icmn_pkg::CHAN_W'(icmn_pkg::CHANNELS - 1));

  always_comb begin
    case (cur_chan)
      icmn_pkg::CHAN_W'(0): mean_sel = mean_red;
      icmn_pkg::CHAN_W'(1): mean_sel = mean_green;
      default:              mean_sel = mean_blue;
    endcase
  end

  assign diff = $signed({2'b00, din.pixel, {icmn_pkg::FRAC_SH{1'b0}}}) -
                $signed({{(icmn_pkg::DIFF_W - icmn_pkg::MEAN_W){1'b0}}, mean_sel});

  always_comb begin
    s1_next.diff = diff;
    s1_next.chan = cur_chan;
    s1_next.row  = dr;
    s1_next.col  = oc;
    s1_next.last = last;
  end

  // ---------------- source position advance ----------------
  assign chan_inc = cur_chan + icmn_pkg::CHAN_W'(1);
  assign col_inc  = {1'b0, cur_col} + icmn_pkg::DIM_W'(1);
  assign row_inc  = {1'b0, cur_row} + icmn_pkg::DIM_W'(1);

  always_comb begin
    cur_chan_next = chan_inc;
    col_adv       = {1'b0, cur_col};
    row_adv       = {1'b0, cur_row};
    if (chan_inc >= icmn_pkg::CHAN_W'(icmn_pkg::CHANNELS)) begin
      cur_chan_next = '0;
      if (col_inc >= ow) begin
        col_adv = '0;
        row_adv = (row_inc >= oh) ? '0 : row_inc;
      end else begin
        col_adv = col_inc;
      end
    end
    // a size shrunk under a running image pulls the position back inside
    if (col_adv >= ow) col_adv = ow - icmn_pkg::DIM_W'(1);
    if (row_adv >= oh) row_adv = oh - icmn_pkg::DIM_W'(1);
    cur_col_next = col_adv[icmn_pkg::POS_W-1:0];
    cur_row_next = row_adv[icmn_pkg::POS_W-1:0];
  end

  // ---------------- handshake ----------------
  assign out_free  = !dout.valid || dout.ready;
  assign s1_move   = s1_valid && out_free;
  assign din.ready = !s1_valid || out_free;
  assign acc       = din.valid && din.ready;
  assign acc_pixel = acc && (din.kind == icmn_pkg::KIND_PIXEL);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row  <= '0;
      cur_col  <= '0;
      cur_chan <= '0;
      top_row  <= '0;
      left_col <= '0;
      flip_on  <= 1'b0;
    end else if (acc) begin
      if (din.kind == icmn_pkg::KIND_START) begin
        top_row  <= top_row_next;
        left_col <= left_col_next;
        flip_on  <= din.mirror;
        cur_row  <= '0;
        cur_col  <= '0;
        cur_chan <= '0;
      end else begin
        cur_row  <= cur_row_next;
        cur_col  <= cur_col_next;
        cur_chan <= cur_chan_next;
      end
    end
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (acc_pixel && hit) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_pixel && hit) s1 <= s1_next;
  end

  // ---------------- scale, round, saturate ----------------
  assign prod = icmn_pkg::PROD_W'(s1.diff) *
                $signed({{(icmn_pkg::PROD_W - icmn_pkg::SCALE_W){1'b0}}, scale});
  // add half an lsb then floor, ties go up
  assign rnd  = prod + icmn_pkg::PROD_W'(1 << (icmn_pkg::FRAC_SH - 1));
  assign quo  = rnd >>> icmn_pkg::FRAC_SH;
  assign quo_top = quo[icmn_pkg::PROD_W-1:icmn_pkg::NORM_W-1];

  always_comb begin
    if ((&quo_top) || !(|quo_top))
      sat = quo[icmn_pkg::NORM_W-1:0];
    else if (quo[icmn_pkg::PROD_W-1])
      sat = {1'b1, {(icmn_pkg::NORM_W-1){1'b0}}};
    else
      sat = {1'b0, {(icmn_pkg::NORM_W-1){1'b1}}};
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (s1_move) begin
      dout.valid <= 1'b1;
    end else if (dout.ready) begin
      dout.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      dout.norm_value    <= sat;
      dout.out_channel   <= s1.chan;
      dout.out_row       <= s1.row;
      dout.out_col       <= s1.col;
      dout.last_of_image <= s1.last;
    end
  end

endmodule

[rtl/core/icmn_checker.sv]
// port-level checks of the crop, mirror and normalize block, bound to the top level
`include "image_crop_mirror_normalize_top_defines.svh"

module icmn_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [icmn_pkg::NORM_W-1:0] norm_value,
  input logic [icmn_pkg::CHAN_W-1:0]       out_channel,
  input logic [icmn_pkg::POS_W-1:0]        out_row,
  input logic [icmn_pkg::POS_W-1:0]        out_col,
  input logic                              last_of_image
);

  // a stalled result keeps its value and destination
  `ICMN_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(norm_value) && $stable(out_row) && $stable(out_col) && $stable(out_channel) && $stable(last_of_image), "stalled result changed")

  // reset drops any pending result
  `ICMN_ASSERT_ALWAYS(a_rst_clear, clk, rst |=> !out_valid, "result pending after reset")

  // only real channel planes leave the block
  `ICMN_ASSERT(a_chan_range, clk, rst, out_valid |-> out_channel < icmn_pkg::CHAN_W'(icmn_pkg::CHANNELS), "channel out of range")

  // the image's final sample is always on the last channel plane
  `ICMN_ASSERT(a_last_chan, clk, rst, out_valid && last_of_image |-> out_channel == icmn_pkg::CHAN_W'(icmn_pkg::CHANNELS - 1), "last mark off the final channel")

endmodule

bind image_crop_mirror_normalize_top icmn_checker u_icmn_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (dout.valid),
  .out_ready     (dout.ready),
  .norm_value    (dout.norm_value),
  .out_channel   (dout.out_channel),
  .out_row       (dout.out_row),
  .out_col       (dout.out_col),
  .last_of_image (dout.last_of_image)
);
